// File: hdl/irtx_pkg.sv
// Shared types and constants for the infrared remote frame transmitter.
// Used by irtx_core and ir_remote_frame_transmitter; depends on nothing.

package irtx_pkg;

  // Default number of code bits in one frame.
  localparam int unsigned CodeBitsDef = 32;

  // Frame phases.
  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhHdrMark   = 3'd1;
  localparam logic [2:0] PhHdrSpace  = 3'd2;
  localparam logic [2:0] PhBitMark   = 3'd3;
  localparam logic [2:0] PhBitSpace  = 3'd4;
  localparam logic [2:0] PhStopMark  = 3'd5;
  localparam logic [2:0] PhEndGap    = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] RegCarrierHalf = 3'd0;
  localparam logic [2:0] RegHdrMark     = 3'd1;
  localparam logic [2:0] RegHdrSpace    = 3'd2;
  localparam logic [2:0] RegBitMark     = 3'd3;
  localparam logic [2:0] RegOneSpace    = 3'd4;
  localparam logic [2:0] RegZeroSpace   = 3'd5;
  localparam logic [2:0] RegEndGap      = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [7:0]  CarrierHalfRst = 8'd13;
  localparam logic [7:0]  HdrMarkRst     = 8'd172;
  localparam logic [15:0] HdrSpaceRst    = 16'd4523;
  localparam logic [7:0]  BitMarkRst     = 8'd15;
  localparam logic [15:0] OneSpaceRst    = 16'd1683;
  localparam logic [15:0] ZeroSpaceRst   = 16'd394;
  localparam logic [15:0] EndGapRst      = 16'd44000;

  typedef struct packed {
    logic [7:0]  carrier_half_period;
    logic [7:0]  header_mark_cycles;
    logic [15:0] header_space_ticks;
    logic [7:0]  bit_mark_cycles;
    logic [15:0] one_space_ticks;
    logic [15:0] zero_space_ticks;
    logic [15:0] end_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic start_rejected;
  } res_t;

endpackage

// File: hdl/irtx_core.sv
// Frame sequencer of the infrared remote transmitter: phase, counters and code shifter.
// Depends on irtx_pkg for the phase codes and the configuration and result structs.

module irtx_core import irtx_pkg::*; #(
  parameter int unsigned CODE_BITS = CodeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        action_i,
  input  logic [31:0] frame_code_i,
  input  cfg_t        cfg_i,
  output res_t        res_o,
  output logic        busy_o
);

  localparam int unsigned BlW = $clog2(CODE_BITS + 1);

  logic [2:0]           phase_q, phase_d;
  logic [BlW-1:0]       bits_left_q, bits_left_d;
  logic [CODE_BITS-1:0] code_q, code_d;
  logic [7:0]           hp_q, hp_d;
  logic [7:0]           cpl_q, cpl_d;
  logic [15:0]          sc_q, sc_d;
  logic                 drive_q, drive_d;
  logic                 rejected;

  logic [7:0]            hp_inc;
  logic [15:0]           sc_inc;
  logic [15:0]           space_len;
  logic                  mark_done;
  logic                  space_done;
  logic [BlW-1:0]        bits_dec;

  assign hp_inc   = hp_q + 8'd1;
  assign sc_inc   = sc_q + 16'd1;

  always_comb begin
    unique case (phase_q)
      PhHdrSpace: space_len = cfg_i.header_space_ticks;
      PhBitSpace: space_len = code_q[CODE_BITS-1] ? cfg_i.one_space_ticks
                                                  : cfg_i.zero_space_ticks;
      default:    space_len = cfg_i.end_gap_ticks;
    endcase
  end

  assign space_done = (sc_inc >= space_len);
  assign bits_dec   = (bits_left_q != '0) ? bits_left_q - BlW'(1) : bits_left_q;

  always_comb begin
    phase_d     = phase_q;
    bits_left_d = bits_left_q;
    code_d      = code_q;
    hp_d        = hp_q;
    cpl_d       = cpl_q;
    sc_d        = sc_q;
    drive_d     = drive_q;
    rejected    = 1'b0;
    mark_done   = 1'b0;

    // One carrier tick: a burst ends only after a full low half.
    if (hp_inc < cfg_i.carrier_half_period) begin
      hp_d = hp_inc;
    end else begin
      hp_d = 8'd0;
      if (drive_q) begin
        drive_d = 1'b0;
      end else if (cpl_q <= 8'd1) begin
        cpl_d     = 8'd0;
        mark_done = 1'b1;
      end else begin
        cpl_d   = cpl_q - 8'd1;
        drive_d = 1'b1;
      end
    end

    if (action_i) begin
      hp_d    = hp_q;
      cpl_d   = cpl_q;
      drive_d = drive_q;
      if (phase_q != PhIdle) begin
        rejected = 1'b1;
      end else begin
        code_d      = CODE_BITS'(frame_code_i);
        bits_left_d = BlW'(CODE_BITS);
        phase_d     = PhHdrMark;
        cpl_d       = cfg_i.header_mark_cycles;
        hp_d        = 8'd0;
        drive_d     = 1'b1;
      end
    end else begin
      unique case (phase_q) inside
        PhHdrMark, PhBitMark, PhStopMark: begin
          if (mark_done) begin
            phase_d = (phase_q == PhHdrMark) ? PhHdrSpace :
                      (phase_q == PhBitMark) ? PhBitSpace : PhEndGap;
            sc_d    = 16'd0;
            drive_d = 1'b0;
          end
        end
        PhHdrSpace, PhBitSpace, PhEndGap: begin
          hp_d    = hp_q;
          cpl_d   = cpl_q;
          drive_d = drive_q;
          sc_d    = sc_inc;
          if (space_done) begin
            if (phase_q == PhEndGap) begin
              phase_d = PhIdle;
              drive_d = 1'b0;
            end else begin
              if (phase_q == PhBitSpace) begin
                code_d      = {code_q[CODE_BITS-2:0], 1'b0};
                bits_left_d = bits_dec;
                phase_d     = (bits_dec == '0) ? PhStopMark : PhBitMark;
              end else begin
                phase_d = PhBitMark;
              end
              cpl_d   = cfg_i.bit_mark_cycles;
              hp_d    = 8'd0;
              drive_d = 1'b1;
            end
          end
        end
        default: begin
          hp_d    = hp_q;
          cpl_d   = cpl_q;
          phase_d = PhIdle;
          drive_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bits_left_q <= '0;
      code_q      <= '0;
      hp_q        <= 8'd0;
      cpl_q       <= 8'd0;
      sc_q        <= 16'd0;
      drive_q     <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bits_left_q <= bits_left_d;
      code_q      <= code_d;
      hp_q        <= hp_d;
      cpl_q       <= cpl_d;
      sc_q        <= sc_d;
      drive_q     <= drive_d;
    end
  end

  assign res_o.pin_level      = drive_d;
  assign res_o.busy_res       = (phase_d != PhIdle);
  assign res_o.start_rejected = rejected;
  assign busy_o               = (phase_q != PhIdle);

endmodule

// File: hdl/ir_remote_frame_transmitter.sv
// Pulse-distance infrared remote transmitter, top level.
// Holds the configuration registers and the result buffer; instantiates irtx_core.
//
// Usage: every input transaction is either a one-microsecond tick (tuser = 0) or a
// start (tuser = 1) carrying the code word in tdata. A start loads the code and the
// block sends header burst, header space, the code bits most significant first
// (burst plus short or long space), a stop burst and an end gap. A start while busy
// is ignored and flagged in its result.
// Each input transaction yields exactly one result transaction with the emitter level,
// the busy flag and the rejection flag as they stand after that input.
// Throughput is one transaction per cycle while tready is high: the sequencer state is
// updated in the cycle of acceptance and the result is registered.
// A skid register behind the output register lets the input side take one more
// transaction when the receiver stalls; s_axis_tready falls only once both are full.
// Reset clears the sequencer to idle with the emitter off, empties the result buffer
// and loads the default timing registers. Configuration writes take effect on the
// next clock edge and are meant to be made while idle.

module ir_remote_frame_transmitter import irtx_pkg::*; #(
  parameter int unsigned CODE_BITS = CodeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] frame_code
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] pin_level, [1] busy_res, [2] start_rejected
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  res_t res_new;
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic in_fire;
  logic core_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.carrier_half_period <= CarrierHalfRst;
      cfg_q.header_mark_cycles  <= HdrMarkRst;
      cfg_q.header_space_ticks  <= HdrSpaceRst;
      cfg_q.bit_mark_cycles     <= BitMarkRst;
      cfg_q.one_space_ticks     <= OneSpaceRst;
      cfg_q.zero_space_ticks    <= ZeroSpaceRst;
      cfg_q.end_gap_ticks       <= EndGapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCarrierHalf: cfg_q.carrier_half_period <= cfg_data_i[7:0];
        RegHdrMark:     cfg_q.header_mark_cycles  <= cfg_data_i[7:0];
        RegHdrSpace:    cfg_q.header_space_ticks  <= cfg_data_i;
        RegBitMark:     cfg_q.bit_mark_cycles     <= cfg_data_i[7:0];
        RegOneSpace:    cfg_q.one_space_ticks     <= cfg_data_i;
        RegZeroSpace:   cfg_q.zero_space_ticks    <= cfg_data_i;
        RegEndGap:      cfg_q.end_gap_ticks       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  irtx_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .action_i     (s_axis_tuser),
    .frame_code_i (s_axis_tdata),
    .cfg_i        (cfg_q),
    .res_o        (res_new),
    .busy_o       (core_busy)
  );

  // The skid register only fills while the output register is held by the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (in_fire) begin
      skid_q <= res_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.start_rejected, out_q.busy_res, out_q.pin_level};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_reject_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_new.start_rejected |-> core_busy && res_new.busy_res)
    else $error("start rejected while the sequencer was idle");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser && !core_busy |=> core_busy)
    else $error("accepted start did not begin a frame");

  a_pin_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_new.pin_level |-> res_new.busy_res)
    else $error("emitter driven while idle");

endmodule
